// ----- rtl/mtp_pkg.sv -----
// Shared types, sizes and register codes for the meshlet triangle packer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mtp_pkg;

  // Sizes of the meshlet storage.
  localparam int VTX_CAP  = 64;
  localparam int PRIM_CAP = 128;

  // Field widths of the ports.
  localparam int GVTX_W    = 32;
  localparam int LOCAL_W   = 6;
  localparam int CFG_VL_W  = 7;
  localparam int CFG_PL_W  = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Internal widths derived from the capacities.
  localparam int VIDX_W = $clog2(VTX_CAP);
  localparam int VC_W   = $clog2(VTX_CAP + 1);
  localparam int PC_W   = $clog2(PRIM_CAP + 1);
  localparam int VL_W   = (VC_W > CFG_VL_W) ? VC_W : CFG_VL_W;
  localparam int PL_W   = (PC_W > CFG_PL_W) ? PC_W : CFG_PL_W;

  // Match vectors are searched in groups of eight lanes.
  localparam int GRP     = 8;
  localparam int NGRP    = (VTX_CAP + GRP - 1) / GRP;
  localparam int HIT_PAD = NGRP * GRP;

  // Command codes.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMITIVE_LIMIT = 1'd1;

  typedef logic [2:0][GVTX_W-1:0] tri_vtx_t;
  typedef logic [2:0][VIDX_W-1:0] tri_idx_t;
  typedef logic [2:0][VTX_CAP-1:0] tri_hit_t;

  // Write request from the commit logic to the vertex lanes.
  typedef struct packed {
    logic [2:0] en;
    tri_idx_t   pos;
  } lane_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/mtp_lane.sv -----
// One vertex lane: holds a single stored global index and compares it with
// the three vertices of an incoming triangle. Depends on mtp_pkg.
`default_nettype none

module mtp_lane
  import mtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [VIDX_W-1:0] lane_idx,
  input  wire logic [VC_W-1:0]   count,
  input  wire logic              cmp_en,
  input  wire tri_vtx_t          cmp_vtx,
  input  wire lane_wr_t          wr,
  input  wire tri_vtx_t          wr_vtx,
  output logic [2:0]             hit_r
);

  logic [GVTX_W-1:0] entry_r;
  logic [GVTX_W-1:0] entry_nxt;
  logic [2:0]        hit_nxt;
  logic              live;

  // Only entries below the fill count are live and can match.
  assign live = VC_W'(lane_idx) < count;

  // Compare the stored vertex with each incoming vertex.
  always_comb begin
    hit_nxt = hit_r;
    if (cmp_en) begin
      for (int j = 0; j < 3; j++) begin
        hit_nxt[j] = live && (entry_r == cmp_vtx[j]);
      end
    end
  end

  // At most one appended vertex lands in this lane.
  always_comb begin
    entry_nxt = entry_r;
    for (int j = 0; j < 3; j++) begin
      if (wr.en[j] && (wr.pos[j] == lane_idx)) begin
        entry_nxt = wr_vtx[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/mtp_merge.sv -----
// Merging stage: turns the per-lane match bits into a found flag and the
// highest matching lane for each triangle vertex. Depends on mtp_pkg.
`default_nettype none

module mtp_merge
  import mtp_pkg::*;
(
  input  wire tri_hit_t hit,
  output logic [2:0]    found,
  output tri_idx_t      idx
);

  // Highest set bit, found first by group of eight and then inside it.
  always_comb begin
    logic [HIT_PAD-1:0] pad;
    logic [GRP-1:0]     grp;
    int                 gsel;
    int                 bsel;
    for (int j = 0; j < 3; j++) begin
      pad  = HIT_PAD'(hit[j]);
      gsel = 0;
      bsel = 0;
      for (int g = 0; g < NGRP; g++) begin
        if (|pad[g*GRP +: GRP]) begin
          gsel = g;
        end
      end
      grp = pad[gsel*GRP +: GRP];
      for (int b = 0; b < GRP; b++) begin
        if (grp[b]) begin
          bsel = b;
        end
      end
      found[j] = |hit[j];
      idx[j]   = VIDX_W'(gsel * GRP + bsel);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/meshlet_triangle_packer.sv -----
// Top level of the meshlet triangle packer: command port, limit registers,
// vertex lanes, merge stage and commit logic. Depends on mtp_pkg, mtp_lane
// and mtp_merge.
//
// On the edge that accepts start, every vertex lane compares its stored
// global index with the three incoming vertices and registers the match; in
// the following cycle (busy high) the merge stage picks the local indices,
// the fit against the limits is decided, new vertices are appended and the
// counts are updated. The result word appears on out_valid for exactly one
// cycle after that, which is also the first cycle in which the next start is
// taken. The receiver cannot stall the result. The vertex store needs no
// clearing after reset: only entries below the vertex count can ever match.
// Limit writes are taken at any time but should be made while the block is
// idle.
`default_nettype none

module meshlet_triangle_packer
  import mtp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_command,
  input  wire logic [GVTX_W-1:0]    in_vertex_a,
  input  wire logic [GVTX_W-1:0]    in_vertex_b,
  input  wire logic [GVTX_W-1:0]    in_vertex_c,
  // Result channel
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic [LOCAL_W-1:0]        out_local_a,
  output logic [LOCAL_W-1:0]        out_local_b,
  output logic [LOCAL_W-1:0]        out_local_c,
  output logic [2:0]                out_appended_mask,
  output logic [CFG_VL_W-1:0]       out_vertex_total,
  output logic [CFG_PL_W-1:0]       out_primitive_total,
  output logic                      out_meshlet_full,
  // Configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_VL_W-1:0] vlim_r;
  logic [CFG_PL_W-1:0] plim_r;
  logic [VC_W-1:0]     vcount_r, vcount_nxt;
  logic [PC_W-1:0]     pcount_r, pcount_nxt;
  logic                cmd_r;
  tri_vtx_t            vtx_r;
  tri_vtx_t            in_vtx;

  logic                accept_cmd;
  logic                cmp_en;
  logic                commit_en;

  logic [2:0]          lane_hit [VTX_CAP];
  tri_hit_t            hit_v;
  logic [2:0]          found;
  tri_idx_t            match_idx;

  logic [VL_W-1:0]     vlim_eff;
  logic [PL_W-1:0]     plim_eff;
  logic                room;
  logic                fit;
  logic                take;
  logic [1:0]          newcnt;
  logic [1:0]          off [3];
  logic [VL_W:0]       vsum;
  tri_idx_t            local_idx;
  lane_wr_t            wr;

  logic                out_valid_r;
  logic                acc_r;
  logic [2:0][LOCAL_W-1:0] loc_r;
  logic [2:0]          mask_r;
  logic [CFG_VL_W-1:0] vtot_r;
  logic [CFG_PL_W-1:0] ptot_r;
  logic                full_r;
  logic                full_nxt;

  assign in_vtx     = {in_vertex_c, in_vertex_b, in_vertex_a};
  assign accept_cmd = start && !busy;

  // Next state of the command sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy      = 1'b0;
    cmp_en    = 1'b0;
    commit_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmp_en = start;
      end
      ST_COMMIT: begin
        busy      = 1'b1;
        commit_en = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Vertex lanes, one stored entry each.
  for (genvar i = 0; i < VTX_CAP; i++) begin : g_lane
    mtp_lane u_lane (
      .clk      (clk),
      .lane_idx (VIDX_W'(i)),
      .count    (vcount_r),
      .cmp_en   (cmp_en),
      .cmp_vtx  (in_vtx),
      .wr       (wr),
      .wr_vtx   (vtx_r),
      .hit_r    (lane_hit[i])
    );
    for (genvar j = 0; j < 3; j++) begin : g_bit
      assign hit_v[j][i] = lane_hit[i][j];
    end
  end

  mtp_merge u_merge (
    .hit   (hit_v),
    .found (found),
    .idx   (match_idx)
  );

  // Effective limits are capped at the storage capacities.
  always_comb begin
    vlim_eff = (VL_W'(vlim_r) < VL_W'(VTX_CAP))  ? VL_W'(vlim_r) : VL_W'(VTX_CAP);
    plim_eff = (PL_W'(plim_r) < PL_W'(PRIM_CAP)) ? PL_W'(plim_r) : PL_W'(PRIM_CAP);
  end

  // Fit check and placement of the unmatched vertices.
  always_comb begin
    off[0] = 2'd0;
    off[1] = {1'b0, !found[0]};
    off[2] = {1'b0, !found[0]} + {1'b0, !found[1]};
    newcnt = off[2] + {1'b0, !found[2]};
    room   = (VL_W'(vcount_r) < vlim_eff) && (PL_W'(pcount_r) < plim_eff);
    vsum   = (VL_W+1)'(vcount_r) + (VL_W+1)'(newcnt);
    fit    = vsum <= {1'b0, vlim_eff};
    take   = (cmd_r == CMD_ADD) && room && fit;
    for (int j = 0; j < 3; j++) begin
      local_idx[j] = found[j] ? match_idx[j]
                              : VIDX_W'(vcount_r + VC_W'(off[j]));
      wr.en[j]     = commit_en && take && !found[j];
      wr.pos[j]    = VIDX_W'(vcount_r + VC_W'(off[j]));
    end
  end

  // Count update and the full flag after this command.
  always_comb begin
    vcount_nxt = vcount_r;
    pcount_nxt = pcount_r;
    if (commit_en) begin
      if (cmd_r == CMD_START) begin
        vcount_nxt = '0;
        pcount_nxt = '0;
      end else if (take) begin
        vcount_nxt = vcount_r + VC_W'(newcnt);
        pcount_nxt = pcount_r + PC_W'(1);
      end
    end
    full_nxt = (VL_W'(vcount_nxt) >= vlim_eff) || (PL_W'(pcount_nxt) >= plim_eff);
  end

  // Control state: sequencer, counts, limit registers and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= '0;
      pcount_r    <= '0;
      vlim_r      <= CFG_VL_W'(64);
      plim_r      <= CFG_PL_W'(126);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      pcount_r    <= pcount_nxt;
      out_valid_r <= commit_en;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERTEX_LIMIT:    vlim_r <= cfg_data[CFG_VL_W-1:0];
          REG_PRIMITIVE_LIMIT: plim_r <= cfg_data[CFG_PL_W-1:0];
          default:             vlim_r <= vlim_r;
        endcase
      end
    end
  end

  // Command word capture and result word registers.
  always_ff @(posedge clk) begin
    if (accept_cmd) begin
      cmd_r <= in_command;
      vtx_r <= in_vtx;
    end
    if (commit_en) begin
      acc_r  <= take;
      for (int j = 0; j < 3; j++) begin
        loc_r[j]  <= take ? LOCAL_W'(local_idx[j]) : '0;
        mask_r[j] <= take && !found[j];
      end
      vtot_r <= CFG_VL_W'(vcount_nxt);
      ptot_r <= CFG_PL_W'(pcount_nxt);
      full_r <= full_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = acc_r;
  assign out_local_a         = loc_r[0];
  assign out_local_b         = loc_r[1];
  assign out_local_c         = loc_r[2];
  assign out_appended_mask   = mask_r;
  assign out_vertex_total    = vtot_r;
  assign out_primitive_total = ptot_r;
  assign out_meshlet_full    = full_r;

`ifndef SYNTH
  // The commit cycle always follows an accepted command.
  a_commit_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |-> $past(start && !busy))
    else $error("commit cycle without an accepted command");

  // A result word is shown only right after a commit cycle.
  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_COMMIT))
    else $error("result word without a commit");

  // The fill count never runs past the vertex storage.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= VC_W'(VTX_CAP))
    else $error("vertex count beyond capacity");

  // A rejected or start command appends nothing.
  a_reject_no_append: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_appended_mask == 3'b000))
    else $error("vertices appended on a rejected command");
`endif

endmodule

`default_nettype wire
